/* rtl/gmp_pkg.sv */
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared types and constants for the grid maze path search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gmp_pkg;

    localparam int MAX_SIZE      = 8;   // largest maze edge in use
    localparam int DIM           = 8;   // stored rows and columns
    localparam int STACK_ENTRIES = 64;  // search stack depth
    localparam int STACK_AW      = 6;   // stack address width

    // step direction of a stack entry, in search order
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    // one stack word: direction in use (in memory, the step already taken), then the cell
    typedef struct packed {
        dir_t       dir;
        logic [2:0] row;
        logic [2:0] col;
    } stack_entry_t;

    // port request into the stack memory
    typedef struct packed {
        logic                wr_en;
        logic [STACK_AW-1:0] wr_addr;
        stack_entry_t        wr_data;
        logic                rd_en;
        logic [STACK_AW-1:0] rd_addr;
    } stack_req_t;

endpackage

`default_nettype wire

/* rtl/gmp_stack_ram.sv */
// ----------------------------------------------------------------------------
// gmp_stack_ram
// Search stack storage: one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_stack_ram (
    input  wire logic                  clk,
    input  wire gmp_pkg::stack_req_t   req,
    output gmp_pkg::stack_entry_t      rdata
);

    gmp_pkg::stack_entry_t mem [gmp_pkg::STACK_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/grid_maze_path_search_unit.sv */
// ----------------------------------------------------------------------------
// grid_maze_path_search_unit
// Loads a square maze row by row, runs a depth-first backtracking search
// from the top-left to the bottom-right cell and emits the path map.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | word
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | row_cells
//   out     | out_valid,out_stall| row_index, path_row, path_found, last_row
//   cfg     | cfg_we             | cfg_data (maze_size)
//
// Rows load at one word per cycle. After the last row the input stalls for
// the search: a start step checks the start cell and seeds the stack, then
// each direction at the top of the stack is tried in turn, and each stack pop
// that leaves an entry behind waits for the registered stack memory read;
// then the map is emitted row by row, held while the output stalls.
// Reset clears control, the path marks and the maze size (8); maze rows and
// the stack memory hold garbage until written.
// A pending output word does not block the next maze from loading.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_path_search_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input rows
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] row_cells,
    // path map rows
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      row_index,
    output logic [7:0]      path_row,
    output logic            path_found,
    output logic            last_row,
    // maze_size register
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,   // taking maze rows
        ST_START = 5'b00010,   // check start cell, seed the stack
        ST_TRY   = 5'b00100,   // try next direction of the top entry
        ST_POP   = 5'b01000,   // stack read returned, resume or drop that entry
        ST_EMIT  = 5'b10000    // send path map rows
    } state_t;

    localparam int DIM = gmp_pkg::DIM;

    state_t                  state_reg, state_next;
    logic [3:0]              size_reg;
    logic [3:0]              rows_reg, rows_next;
    logic [DIM-1:0]          grid_reg  [DIM];
    logic [DIM-1:0]          marks_reg [DIM];
    logic [DIM-1:0]          marks_next[DIM];
    gmp_pkg::stack_entry_t   top_reg, top_next;
    logic [6:0]              depth_reg, depth_next;
    logic                    found_reg, found_next;
    logic [3:0]              emit_reg, emit_next;
    logic                    out_valid_reg;
    logic                    out_load;

    gmp_pkg::stack_req_t     ram_req;
    gmp_pkg::stack_entry_t   ram_rdata;

    logic       in_accept;
    logic [3:0] n_eff;
    logic [2:0] n_m1;
    logic [7:0] colmask;
    logic [3:0] row_pos;
    logic [6:0] depth_m1;
    logic [6:0] depth_m2;

    // neighbor of the top entry in its current direction
    logic [2:0] nb_row;
    logic [2:0] nb_col;
    logic       nb_inside;
    logic       nb_free;
    logic       nb_goal;

    // effective size: 0 acts as 1, above MAX_SIZE clamps
    always_comb
    begin
        if (size_reg == 4'd0)
        begin
            n_eff = 4'd1;
        end
        else if (size_reg > 4'(gmp_pkg::MAX_SIZE))
        begin
            n_eff = 4'(gmp_pkg::MAX_SIZE);
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign n_m1     = 3'(n_eff - 4'd1);
    assign colmask  = 8'((9'd1 << n_eff) - 9'd1);
    assign row_pos  = (rows_reg >= n_eff) ? 4'd0 : rows_reg;
    assign depth_m1 = depth_reg - 7'd1;
    assign depth_m2 = depth_reg - 7'd2;

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        nb_row    = top_reg.row;
        nb_col    = top_reg.col;
        nb_inside = 1'b0;
        unique case (top_reg.dir)
            gmp_pkg::DIR_DOWN:
            begin
                nb_row    = top_reg.row + 3'd1;
                nb_inside = ({1'b0, top_reg.row} + 4'd1) < n_eff;
            end
            gmp_pkg::DIR_RIGHT:
            begin
                nb_col    = top_reg.col + 3'd1;
                nb_inside = ({1'b0, top_reg.col} + 4'd1) < n_eff;
            end
            gmp_pkg::DIR_LEFT:
            begin
                nb_col    = top_reg.col - 3'd1;
                nb_inside = (top_reg.col != 3'd0);
            end
            gmp_pkg::DIR_UP:
            begin
                nb_row    = top_reg.row - 3'd1;
                nb_inside = (top_reg.row != 3'd0);
            end
            default:
            begin
                nb_inside = 1'b0;
            end
        endcase
    end

    assign nb_free = nb_inside && grid_reg[nb_row][nb_col] && !marks_reg[nb_row][nb_col];
    assign nb_goal = (nb_row == n_m1) && (nb_col == n_m1);

    // Stack memory: pushes happen only in ST_TRY, reads are issued only on a
    // pop, so a read and a write never meet in the same cycle.
    gmp_stack_ram u_stack (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        rows_next  = rows_reg;
        top_next   = top_reg;
        depth_next = depth_reg;
        found_next = found_reg;
        emit_next  = emit_reg;
        marks_next = marks_reg;
        ram_req    = '0;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if ((row_pos + 4'd1) < n_eff)
                    begin
                        rows_next = row_pos + 4'd1;
                    end
                    else
                    begin
                        rows_next  = 4'd0;
                        state_next = ST_START;
                        found_next = 1'b0;
                        for (int i = 0; i < DIM; i++)
                        begin
                            marks_next[i] = '0;
                        end
                    end
                end
            end

            ST_START:
            begin
                emit_next  = 4'd0;
                depth_next = 7'd0;
                if (!grid_reg[0][0])
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    marks_next[0][0] = 1'b1;
                    if (n_eff == 4'd1)
                    begin
                        found_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        top_next   = '0;
                        depth_next = 7'd1;
                        state_next = ST_TRY;
                    end
                end
            end

            ST_TRY:
            begin
                if (nb_free)
                begin
                    marks_next[nb_row][nb_col] = 1'b1;
                    if (nb_goal)
                    begin
                        found_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else if (depth_reg < 7'(gmp_pkg::STACK_ENTRIES))
                    begin
                        // spill the top entry, neighbor becomes the new top
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = depth_m1[gmp_pkg::STACK_AW-1:0];
                        ram_req.wr_data = top_reg;
                        top_next.dir    = gmp_pkg::DIR_DOWN;
                        top_next.row    = nb_row;
                        top_next.col    = nb_col;
                        depth_next      = depth_reg + 7'd1;
                    end
                end
                else if (top_reg.dir != gmp_pkg::DIR_UP)
                begin
                    top_next.dir = gmp_pkg::dir_t'(top_reg.dir + 2'd1);
                end
                else
                begin
                    // exhausted: leave the cell and drop the entry
                    marks_next[top_reg.row][top_reg.col] = 1'b0;
                    depth_next = depth_m1;
                    if (depth_reg == 7'd1)
                    begin
                        found_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = depth_m2[gmp_pkg::STACK_AW-1:0];
                        state_next      = ST_POP;
                    end
                end
            end

            ST_POP:
            begin
                if (ram_rdata.dir != gmp_pkg::DIR_UP)
                begin
                    top_next     = ram_rdata;
                    top_next.dir = gmp_pkg::dir_t'(ram_rdata.dir + 2'd1);
                    state_next   = ST_TRY;
                end
                else
                begin
                    marks_next[ram_rdata.row][ram_rdata.col] = 1'b0;
                    depth_next = depth_m1;
                    if (depth_reg == 7'd1)
                    begin
                        found_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = depth_m2[gmp_pkg::STACK_AW-1:0];
                    end
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    if (emit_reg[2:0] == n_m1)
                    begin
                        emit_next  = 4'd0;
                        depth_next = 7'd0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        emit_next = emit_reg + 4'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // a size write restarts loading
        if (cfg_we)
        begin
            rows_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            size_reg      <= 4'd8;
            rows_reg      <= 4'd0;
            depth_reg     <= 7'd0;
            found_reg     <= 1'b0;
            emit_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIM; i++)
            begin
                marks_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            depth_reg <= depth_next;
            found_reg <= found_next;
            emit_reg  <= emit_next;
            marks_reg <= marks_next;
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (in_accept)
        begin
            grid_reg[row_pos[2:0]] <= row_cells;
        end
        if (out_load)
        begin
            row_index  <= emit_reg[2:0];
            path_row   <= marks_reg[emit_reg[2:0]] & colmask;
            path_found <= found_reg;
            last_row   <= (emit_reg[2:0] == n_m1);
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= 7'(gmp_pkg::STACK_ENTRIES))
        else $error("stack depth beyond capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP |-> depth_reg != 7'd0)
        else $error("stack read with empty stack");

    a_top_marked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TRY |-> marks_reg[top_reg.row][top_reg.col])
        else $error("top of stack cell not on path");

    a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !path_found |-> path_row == 8'd0)
        else $error("marks left behind after failed search");
`endif

endmodule

`default_nettype wire
